// ===== rtl/mctt_pkg.sv =====
// ---------------------------------------------------------------------------
// mctt_pkg
// Shared types and constants of the midi clock tempo tracker.
// ---------------------------------------------------------------------------
package mctt_pkg;

  // event operation codes
  localparam logic [2:0] OP_PULSE   = 3'd0;
  localparam logic [2:0] OP_CONSUME = 3'd1;
  localparam logic [2:0] OP_START   = 3'd2;
  localparam logic [2:0] OP_STOP    = 3'd3;
  localparam logic [2:0] OP_CONT    = 3'd4;

  // pulse transports
  localparam logic SRC_DIN = 1'b0;

  // configuration register indexes
  localparam logic REG_SYNC_SOURCE = 1'b0;
  localparam logic REG_PPQ         = 1'b1;

  // tempo constants, Q10.8 bpm
  localparam logic [17:0] TEMPO_RESET = 18'd30720;
  localparam logic [17:0] TEMPO_MAX   = 18'h3FFFF;
  // 0.25 * 60e6 * 256 * 4, numerator term of the smoothing update
  localparam logic [51:0] QUARTER_NUM = 52'd15360000000;

  // serial divider widths
  localparam int unsigned REM_W = 34;
  localparam int unsigned DVD_W = 32;
  localparam int unsigned CNT_W = 6;

  // request to the serial divider
  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] steps;
    logic [REM_W-1:0] rem_init;
    logic [DVD_W-1:0] dividend;
    logic [REM_W-1:0] divisor;
  } div_req_t;

  // response of the serial divider
  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== rtl/mctt_sdiv.sv =====
// ---------------------------------------------------------------------------
// mctt_sdiv
// Restoring divider, one quotient bit per cycle, shared by tempo and phase.
// ---------------------------------------------------------------------------
module mctt_sdiv (
  input  logic              clk,
  input  logic              rst_n,
  input  mctt_pkg::div_req_t req,
  output mctt_pkg::div_rsp_t rsp
);
  import mctt_pkg::*;

  logic [REM_W-1:0] rem_r,  rem_nxt;
  logic [DVD_W-1:0] dvd_r,  dvd_nxt;
  logic [REM_W-1:0] dvs_r,  dvs_nxt;
  logic [DVD_W-1:0] quo_r,  quo_nxt;
  logic [CNT_W-1:0] cnt_r,  cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [REM_W:0]   trial;

  // one trial subtraction per cycle
  always_comb begin
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, dvd_r[DVD_W-1]} - {1'b0, dvs_r};
    if (req.start) begin
      rem_nxt  = req.rem_init;
      dvd_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
      quo_nxt  = '0;
      cnt_nxt  = req.steps;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[REM_W]) begin
        rem_nxt = trial[REM_W-1:0];
      end else begin
        rem_nxt = {rem_r[REM_W-2:0], dvd_r[DVD_W-1]};
      end
      quo_nxt = {quo_r[DVD_W-2:0], ~trial[REM_W]};
      dvd_nxt = {dvd_r[DVD_W-2:0], 1'b0};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

// ===== rtl/midi_clock_tempo_tracker.sv =====
// ---------------------------------------------------------------------------
// midi_clock_tempo_tracker
// Tracks MIDI clock pulses, smooths tempo and reports quarter-note phase.
// ---------------------------------------------------------------------------
// One item is taken at a time. Start, stop, continue, unknown codes, USB
// pulses, DIN pulses that do not close a tempo group and consume items with
// a zero PPQ register pass through the execute and done states only; a DIN
// pulse that closes a group over a zero span also passes the scale state. A
// consume item waits for the 32 steps of the shared bit-serial divider. A DIN
// pulse that closes a tempo group runs 32 steps of the bit-serial
// multiplier for 3 * tempo * delta, then 19 steps of the divider.
// A finished result sits in the output register, so the next item is taken
// while it waits; a later result that finds the register still full holds
// the sequencer until the register empties.
module midi_clock_tempo_tracker #(
  parameter int PULSES_PER_TEMPO_UPDATE = 6,
  parameter int CLOCK_PPQ               = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [9:0]  cfg_data,
  // input items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] now_us
  input  logic [3:0]  in_tuser,   // [2:0] op, [3] source
  // result items
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata   // [17:0] tempo_q8, [49:18] phase_delta_q16,
                                  // [50] playing, [55:51] zero
);
  import mctt_pkg::*;

  localparam logic [4:0]  PPT   = 5'(PULSES_PER_TEMPO_UPDATE);
  localparam logic [31:0] RATIO = 32'(CLOCK_PPQ / PULSES_PER_TEMPO_UPDATE);
  localparam logic [9:0]  PPQ_RESET = 10'(CLOCK_PPQ);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_EXEC   = 7'b0000010,
    S_SCALE  = 7'b0000100,
    S_MUL    = 7'b0001000,
    S_ADD    = 7'b0010000,
    S_DSTART = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  // divider wait, tracked beside the sequencer states
  typedef enum logic [1:0] {
    W_NONE  = 2'b01,
    W_DIV   = 2'b10
  } wait_t;

  state_t        state_r,  state_nxt;
  wait_t         wait_r,   wait_nxt;

  logic          sync_r;
  logic [9:0]    ppq_r;
  logic [15:0]   pend_r,   pend_nxt;
  logic [4:0]    gc_r,     gc_nxt;
  logic [31:0]   last_r,   last_nxt;
  logic [17:0]   tempo_r,  tempo_nxt;
  logic          run_r,    run_nxt;

  logic [2:0]    op_r;
  logic          src_r;
  logic [31:0]   now_r;
  logic [31:0]   diff_r,   diff_nxt;
  logic [31:0]   delta_r,  delta_nxt;
  logic [19:0]   m3t_r,    m3t_nxt;
  logic [52:0]   mul_r,    mul_nxt;
  logic [4:0]    mcnt_r,   mcnt_nxt;
  logic          sat_r,    sat_nxt;
  logic          dtempo_r, dtempo_nxt;
  logic [31:0]   phase_r,  phase_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [55:0]   out_data_r,  out_data_nxt;

  logic [4:0]    gc_inc;
  logic [31:0]   scaled;
  logic [20:0]   psum;
  logic [51:0]   num;
  logic [33:0]   dvs_tempo;
  logic          in_acc;
  logic          out_free;

  div_req_t      dreq;
  div_rsp_t      drsp;

  mctt_sdiv u_sdiv (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == S_IDLE) && (wait_r == W_NONE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign gc_inc    = gc_r + 5'd1;
  assign scaled    = 32'(diff_r * RATIO);
  assign psum      = mul_r[52:32] + (mul_r[0] ? {1'b0, m3t_r} : 21'd0);
  assign num       = mul_r[51:0] + QUARTER_NUM;
  assign dvs_tempo = {delta_r, 2'b00};

  // sequencer and state updates
  always_comb begin
    state_nxt     = state_r;
    wait_nxt      = wait_r;
    pend_nxt      = pend_r;
    gc_nxt        = gc_r;
    last_nxt      = last_r;
    tempo_nxt     = tempo_r;
    run_nxt       = run_r;
    diff_nxt      = diff_r;
    delta_nxt     = delta_r;
    m3t_nxt       = m3t_r;
    mul_nxt       = mul_r;
    mcnt_nxt      = mcnt_r;
    sat_nxt       = sat_r;
    dtempo_nxt    = dtempo_r;
    phase_nxt     = phase_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    dreq          = '0;

    if (wait_r == W_DIV) begin
      // divider running, finish when it reports done
      if (drsp.done) begin
        if (dtempo_r) begin
          tempo_nxt = (sat_r || drsp.quotient[18]) ? TEMPO_MAX : drsp.quotient[17:0];
        end else begin
          phase_nxt = drsp.quotient;
        end
        wait_nxt  = W_NONE;
        state_nxt = S_DONE;
      end
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            state_nxt = S_EXEC;
          end
        end
        S_EXEC: begin
          phase_nxt = '0;
          state_nxt = S_DONE;
          unique case (op_r) inside
            OP_PULSE: begin
              if (src_r == sync_r && pend_r != 16'hFFFF) begin
                pend_nxt = pend_r + 16'd1;
              end
              if (src_r == SRC_DIN) begin
                if (gc_inc >= PPT) begin
                  gc_nxt    = gc_inc - PPT;
                  diff_nxt  = now_r - last_r;
                  last_nxt  = now_r;
                  state_nxt = S_SCALE;
                end else begin
                  gc_nxt = gc_inc;
                end
              end
            end
            OP_CONSUME: begin
              pend_nxt = '0;
              if (ppq_r != 10'd0) begin
                dreq.start    = 1'b1;
                dreq.steps    = CNT_W'(32);
                dreq.rem_init = '0;
                dreq.dividend = {pend_r, 16'd0};
                dreq.divisor  = {24'd0, ppq_r};
                dtempo_nxt    = 1'b0;
                wait_nxt      = W_DIV;
                state_nxt     = S_IDLE;
              end
            end
            OP_START, OP_CONT: run_nxt = 1'b1;
            OP_STOP:           run_nxt = 1'b0;
            default: ;
          endcase
        end
        S_SCALE: begin
          // quarter-note delta, zero skips the update
          delta_nxt = scaled;
          m3t_nxt   = {2'b00, tempo_r} + {1'b0, tempo_r, 1'b0};
          mul_nxt   = {21'd0, scaled};
          mcnt_nxt  = '0;
          state_nxt = (scaled == 32'd0) ? S_DONE : S_MUL;
        end
        S_MUL: begin
          // shift-add, one multiplier bit per cycle
          mul_nxt  = {1'b0, psum, mul_r[31:1]};
          mcnt_nxt = mcnt_r + 5'd1;
          if (mcnt_r == 5'd31) begin
            state_nxt = S_ADD;
          end
        end
        S_ADD: begin
          mul_nxt   = {1'b0, num};
          state_nxt = S_DSTART;
        end
        S_DSTART: begin
          // high part at or above the divisor means the quotient overflows
          sat_nxt       = {1'b0, mul_r[51:19]} >= dvs_tempo;
          dreq.start    = 1'b1;
          dreq.steps    = CNT_W'(19);
          dreq.rem_init = {1'b0, mul_r[51:19]};
          dreq.dividend = {mul_r[18:0], 13'd0};
          dreq.divisor  = dvs_tempo;
          dtempo_nxt    = 1'b1;
          wait_nxt      = W_DIV;
          state_nxt     = S_IDLE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = {5'd0, run_r, phase_r, tempo_r};
            state_nxt     = S_IDLE;
          end
        end
        default: state_nxt = S_IDLE;
      endcase
    end
  end

  // control state and architectural registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wait_r      <= W_NONE;
      sync_r      <= 1'b0;
      ppq_r       <= PPQ_RESET;
      pend_r      <= '0;
      gc_r        <= '0;
      last_r      <= '0;
      tempo_r     <= TEMPO_RESET;
      run_r       <= 1'b0;
      mcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wait_r      <= wait_nxt;
      pend_r      <= pend_nxt;
      gc_r        <= gc_nxt;
      last_r      <= last_nxt;
      tempo_r     <= tempo_nxt;
      run_r       <= run_nxt;
      mcnt_r      <= mcnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_SYNC_SOURCE: sync_r <= cfg_data[0];
          REG_PPQ:         ppq_r  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // item capture and datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r  <= in_tuser[2:0];
      src_r <= in_tuser[3];
      now_r <= in_tdata;
    end
    diff_r     <= diff_nxt;
    delta_r    <= delta_nxt;
    m3t_r      <= m3t_nxt;
    mul_r      <= mul_nxt;
    sat_r      <= sat_nxt;
    dtempo_r   <= dtempo_nxt;
    phase_r    <= phase_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== rtl/mctt_checker.sv =====
// ---------------------------------------------------------------------------
// mctt_checker
// Port-level checks of the tempo tracker, bound to the top level.
// ---------------------------------------------------------------------------
module mctt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic        cfg_index,
  input logic [9:0]  cfg_data,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [31:0] in_tdata,
  input logic [3:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // one item at a time: busy right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item taken while busy");

  // padding bits stay clear
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[55:51] == 5'd0)
    else $error("nonzero padding in result");

  // reset empties the output register
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind midi_clock_tempo_tracker mctt_checker u_mctt_checker (.*);
